### rtl/core/fab_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fab_pkg
// shared types, constants and the divide-by-255 helper of the blend writer
// ---------------------------------------------------------------------------
package fab_pkg;

  localparam int PixW     = 32;
  localparam int ChanW    = 8;
  localparam int CoordW   = 12;
  localparam int DimW     = 13;   // holds a frame dimension up to 4096
  localparam int CfgW     = 9;
  localparam int AlphaLsb = 24;
  localparam int RedLsb   = 16;
  localparam int GreenLsb = 8;
  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  typedef enum logic {
    OP_BLEND = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  // memory port controls
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

  // floor(n / 255) for n up to 255 * 255
  function automatic logic [ChanW-1:0] div255(input logic [15:0] n);
    logic [15:0] t;
    t = n + {8'd0, n[15:8]} + 16'd1;
    return t[15:8];
  endfunction

endpackage

### rtl/core/fab_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fab_mem
// single-port pixel store, one write and one registered read per cycle on the shared address
// ---------------------------------------------------------------------------
module fab_mem #(
  parameter int Depth = 65536,
  parameter int AddrW = 16
) (
  input  logic                      clk_i,
  input  fab_pkg::mem_ctrl_t        ctrl_i,
  input  logic [AddrW-1:0]          addr_i,
  input  logic [fab_pkg::PixW-1:0]  wdata_i,
  output logic [fab_pkg::PixW-1:0]  rdata_o
);
  import fab_pkg::*;

  logic [PixW-1:0] mem_q [Depth];
  logic [PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctrl_i.rd_en) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fab_blend.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fab_blend
// per-channel alpha blend: registered weighted sums, then divide by 255
// ---------------------------------------------------------------------------
module fab_blend (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic [fab_pkg::PixW-1:0]  bg_i,
  input  logic [fab_pkg::PixW-1:0]  ov_i,
  output logic [fab_pkg::PixW-1:0]  pix_o
);
  import fab_pkg::*;

  logic [ChanW-1:0] alpha;
  logic [ChanW-1:0] inv_alpha;
  logic [15:0]      sum_d [3];
  logic [15:0]      sum_q [3];

  assign alpha     = ov_i[AlphaLsb +: ChanW];
  assign inv_alpha = ChanMax - alpha;

  // an opaque overlay ignores the stored pixel entirely
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = ((alpha == ChanMax) ? 16'd0 : 16'(bg_i[c*ChanW +: ChanW] * inv_alpha))
               + 16'(ov_i[c*ChanW +: ChanW] * alpha);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= sum_d;
    end
  end

  // alpha forced opaque
  assign pix_o = {ChanMax, div255(sum_q[2]), div255(sum_q[1]), div255(sum_q[0])};

endmodule

### rtl/core/framebuffer_alpha_blend_write.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// framebuffer_alpha_blend_write
// argb8888 framebuffer with bounds-checked alpha-blended writes and reads
// ---------------------------------------------------------------------------
// usage
//   s_axis carries one item: tuser is the operation (blend or read), tdata
//   holds x, y and the overlay color. m_axis returns one item per input:
//   tuser is the in-range flag, tdata the stored pixel on an in-range read
//   and zero otherwise. frame_width and frame_height are to be written through the
//   plain cfg port only while the block is idle; the block does not enforce this.
// timing
//   one item at a time; from acceptance to the result register an in-range
//   blend goes through address multiply, memory read, blend sums, divide and
//   write back and result load; an in-range read skips divide and write
//   back, and an out-of-range item or a transparent blend goes from the
//   address step straight to the result load, as the single memory port and
//   the read-modify-write sequence demand. the next item is accepted in the
//   cycle after the result is loaded, even if the receiver has not yet taken it.
// reset
//   frame size returns to 256 x 256, the pipeline empties; pixel contents
//   are not cleared and hold nothing defined until written.
// stall
//   a held result blocks only the next result load; the item behind it
//   waits in its final step until the output register frees up.
// ---------------------------------------------------------------------------
module framebuffer_alpha_blend_write #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [fab_pkg::CfgW-1:0]      cfg_wdata_i,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [55:0]                   s_axis_tdata,   // x[11:0], y[23:12], color[55:24]
  input  logic                          s_axis_tuser,   // operation
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [fab_pkg::PixW-1:0]      m_axis_tdata,   // pixel
  output logic                          m_axis_tuser    // in_range
);
  import fab_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int LinW  = CoordW + DimW;

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADDR  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CALC  = 3'd3;
  localparam logic [2:0] ST_WRITE = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // configuration registers
  logic [CfgW-1:0] frame_width_q, frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= CfgW'(256);
      frame_height_q <= CfgW'(256);
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective frame size, saturated to the store dimensions
  logic [DimW-1:0] width_ext, height_ext, w_eff, h_eff;
  assign width_ext  = DimW'(frame_width_q);
  assign height_ext = DimW'(frame_height_q);
  assign w_eff = (width_ext  > DimW'(MAX_WIDTH))  ? DimW'(MAX_WIDTH)  : width_ext;
  assign h_eff = (height_ext > DimW'(MAX_HEIGHT)) ? DimW'(MAX_HEIGHT) : height_ext;

  // input item fields
  logic [CoordW-1:0] in_x, in_y;
  logic [PixW-1:0]   in_color;
  logic              in_hit;
  assign in_x     = s_axis_tdata[11:0];
  assign in_y     = s_axis_tdata[23:12];
  assign in_color = s_axis_tdata[55:24];
  assign in_hit   = ({1'b0, in_x} < w_eff) && ({1'b0, in_y} < h_eff);

  // sequencer and item registers
  logic [2:0]        state_q, state_d;
  logic              op_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [PixW-1:0]   color_q;
  logic              hit_q;
  logic [AddrW-1:0]  addr_q;
  logic [PixW-1:0]   res_pix_q, res_pix_d;
  logic              out_valid_q;
  logic [PixW-1:0]   out_pix_q;
  logic              out_hit_q;

  logic              in_acc;
  logic              out_free;
  logic [LinW-1:0]   lin_addr;
  logic              no_access;
  mem_ctrl_t         mem_ctrl;
  logic [PixW-1:0]   mem_rdata;
  logic [PixW-1:0]   blend_pix;
  logic              blend_load;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // row-major address with the effective width as stride
  assign lin_addr  = LinW'(y_q * w_eff) + LinW'(x_q);
  // out of range, or a fully transparent blend: nothing to touch
  assign no_access = !hit_q ||
                     ((op_e'(op_q) == OP_BLEND) && (color_q[AlphaLsb +: ChanW] == '0));

  always_comb begin
    state_d        = state_q;
    res_pix_d      = res_pix_q;
    mem_ctrl.wr_en = 1'b0;
    mem_ctrl.rd_en = 1'b0;
    blend_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_ADDR;
      end
      ST_ADDR: begin
        res_pix_d = '0;
        state_d   = no_access ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        mem_ctrl.rd_en = 1'b1;
        state_d        = ST_CALC;
      end
      ST_CALC: begin
        if (op_e'(op_q) == OP_READ) begin
          res_pix_d = mem_rdata;
          state_d   = ST_DONE;
        end else begin
          blend_load = 1'b1;
          state_d    = ST_WRITE;
        end
      end
      ST_WRITE: begin
        mem_ctrl.wr_en = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= s_axis_tuser;
      x_q     <= in_x;
      y_q     <= in_y;
      color_q <= in_color;
      hit_q   <= in_hit;
    end
    if (state_q == ST_ADDR) begin
      addr_q <= lin_addr[AddrW-1:0];
    end
    res_pix_q <= res_pix_d;
    if ((state_q == ST_DONE) && out_free) begin
      out_pix_q <= res_pix_q;
      out_hit_q <= hit_q;
    end
  end

  fab_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .addr_i  (addr_q),
    .wdata_i (blend_pix),
    .rdata_o (mem_rdata)
  );

  fab_blend u_blend (
    .clk_i  (clk_i),
    .load_i (blend_load),
    .bg_i   (mem_rdata),
    .ov_i   (color_q),
    .pix_o  (blend_pix)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the argb8888 alpha-blend framebuffer writer
// ---------------------------------------------------------------------------
// blend and read items go into s_axis. every accepted item is run through a
// shadow framebuffer here, and the result it should give is queued. a
// checker pops one entry per m_axis item and compares in_range and pixel.
// the frame size moves through reset, unit, empty, oversized, odd and
// single-row settings. random gaps and stalls are applied on both sides,
// and none in the closing phase.
// ---------------------------------------------------------------------------
module testbench;

  import fab_pkg::*;

  localparam int MaxW         = 256;
  localparam int MaxH         = 256;
  localparam int StoreDepth   = MaxW * MaxH;
  localparam int BlockLatency = 5;      // acceptance to result register, longest case
  localparam int StallLimit   = 4000;   // cycles without any handshake

  // one result item as the block should return it
  typedef struct packed {
    logic            in_range;
    logic [PixW-1:0] pixel;
  } px_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  reg_idx_e          cfg_idx_i;
  logic [CfgW-1:0]   cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [55:0]       s_axis_tdata;   // x[11:0], y[23:12], color[55:24]
  logic              s_axis_tuser;   // operation
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [PixW-1:0]   m_axis_tdata;   // pixel
  logic              m_axis_tuser;   // in_range

  // shadow framebuffer: contents plus a written flag per address
  logic [PixW-1:0]   shadow_px [StoreDepth];
  bit                shadow_written [StoreDepth];
  logic [CfgW-1:0]   shadow_width;
  logic [CfgW-1:0]   shadow_height;

  px_result_t        expected_px_q [$];
  px_result_t        exp_px;
  int                fail_count;
  int                quiet_cycles;
  bit                calm;           // no gaps and no stalls when set

  framebuffer_alpha_blend_write #(
    .MAX_WIDTH  (MaxW),
    .MAX_HEIGHT (MaxH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // frame size as the block uses it, saturated to the store dimensions
  function automatic int eff_width();
    return (shadow_width > MaxW) ? MaxW : int'(shadow_width);
  endfunction

  function automatic int eff_height();
    return (shadow_height > MaxH) ? MaxH : int'(shadow_height);
  endfunction

  // per channel floor((bg*(255-a) + ov*a) / 255), alpha forced opaque
  function automatic logic [PixW-1:0] blend_argb(logic [PixW-1:0] bg, logic [PixW-1:0] ov);
    int unsigned     a;
    int unsigned     bgc;
    int unsigned     ovc;
    int              c;
    logic [PixW-1:0] res;
    a = {24'd0, ov[AlphaLsb +: ChanW]};
    res = '0;
    for (c = 0; c < 3; c++) begin
      bgc = {24'd0, bg[c*ChanW +: ChanW]};
      ovc = {24'd0, ov[c*ChanW +: ChanW]};
      res[c*ChanW +: ChanW] = ChanW'((bgc * (ChanMax - a) + ovc * a) / ChanMax);
    end
    res[AlphaLsb +: ChanW] = ChanMax;
    return res;
  endfunction

  // applies one accepted item to the shadow framebuffer, returns its result
  function automatic px_result_t blend_or_fetch(op_e op, logic [CoordW-1:0] x,
                                                logic [CoordW-1:0] y, logic [PixW-1:0] color);
    px_result_t r;
    int         w;
    int         h;
    int         addr;
    w = eff_width();
    h = eff_height();
    r = '0;
    if (x < w && y < h) begin
      r.in_range = 1'b1;
      addr = y * w + x;
      if (op == OP_READ) begin
        r.pixel = shadow_px[addr];
      end else if (color[AlphaLsb +: ChanW] != 8'h00) begin
        shadow_px[addr]      = blend_argb(shadow_px[addr], color);
        shadow_written[addr] = 1'b1;
      end
    end
    return r;
  endfunction

  // sends one item; a read of an unwritten pixel becomes an opaque write,
  // and any blend onto one is made opaque
  task automatic send_px(op_e op, logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                         logic [PixW-1:0] color);
    int addr;
    if (x < eff_width() && y < eff_height()) begin
      addr = y * eff_width() + x;
      if (!shadow_written[addr]) begin
        op = OP_BLEND;
        color[AlphaLsb +: ChanW] = ChanMax;
      end
    end
    // optional gap before the item goes up
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {color, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_px_q.push_back(blend_or_fetch(op, x, y, color));
    @(negedge clk_i);
  endtask

  // lowers valid and waits until every queued result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_px_q.size() != 0) @(negedge clk_i);
    repeat (BlockLatency + 2) @(negedge clk_i);
  endtask

  task automatic set_frame_size(int w, int h);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FRAME_WIDTH;
    cfg_wdata_i <= w[CfgW-1:0];
    @(negedge clk_i);
    cfg_idx_i   <= REG_FRAME_HEIGHT;
    cfg_wdata_i <= h[CfgW-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_width  = w[CfgW-1:0];
    shadow_height = h[CfgW-1:0];
    @(negedge clk_i);
  endtask

  // random items: a small hot window so reads hit written pixels, the
  // whole frame, and raw 12-bit coordinates that are mostly out of range
  task automatic run_random(int n);
    int              i;
    int              pick;
    int              w;
    int              h;
    int              lim;
    op_e             op;
    logic [11:0]     x;
    logic [11:0]     y;
    logic [PixW-1:0] color;
    for (i = 0; i < n; i++) begin
      w = eff_width();
      h = eff_height();
      pick = $urandom_range(0, 99);
      if (pick < 12 || w == 0 || h == 0) begin
        x = 12'($urandom_range(0, 4095));
        y = 12'($urandom_range(0, 4095));
      end else if (pick < 55) begin
        lim = (w < 6) ? w : 6;
        x = 12'($urandom_range(0, lim - 1));
        lim = (h < 6) ? h : 6;
        y = 12'($urandom_range(0, lim - 1));
      end else begin
        x = 12'($urandom_range(0, w - 1));
        y = 12'($urandom_range(0, h - 1));
      end
      op    = ($urandom_range(0, 99) < 45) ? OP_READ : OP_BLEND;
      color = $urandom;
      pick  = $urandom_range(0, 9);
      if (pick < 2) color[AlphaLsb +: ChanW] = 8'h00;
      else if (pick < 4) color[AlphaLsb +: ChanW] = ChanMax;
      send_px(op, x, y, color);
    end
  endtask

  // corners, edges, zero/full/partial alpha, back-to-back same-pixel blends
  task automatic test_directed();
    send_px(OP_BLEND, 12'd0,    12'd0,    32'hFF12_3456);
    send_px(OP_READ,  12'd0,    12'd0,    32'h0000_0000);
    send_px(OP_BLEND, 12'd0,    12'd0,    32'h00FF_FFFF);   // transparent, no write
    send_px(OP_READ,  12'd0,    12'd0,    32'h0000_0000);
    send_px(OP_BLEND, 12'd0,    12'd0,    32'h80FF_00FF);
    send_px(OP_READ,  12'd0,    12'd0,    32'h0000_0000);
    // same pixel written on consecutive items
    send_px(OP_BLEND, 12'd0,    12'd0,    32'h01FF_FFFF);
    send_px(OP_BLEND, 12'd0,    12'd0,    32'hFE00_0000);
    send_px(OP_BLEND, 12'd0,    12'd0,    32'h7F80_40C0);
    send_px(OP_READ,  12'd0,    12'd0,    32'h0000_0000);
    send_px(OP_BLEND, 12'd255,  12'd255,  32'hFFFF_FFFF);
    send_px(OP_READ,  12'd255,  12'd255,  32'hFFFF_FFFF);   // color ignored on read
    send_px(OP_BLEND, 12'd255,  12'd0,    32'hFF00_0000);
    send_px(OP_READ,  12'd255,  12'd0,    32'h0000_0000);
    send_px(OP_BLEND, 12'd0,    12'd255,  32'hFFA5_5A0F);
    send_px(OP_READ,  12'd0,    12'd255,  32'h0000_0000);
    // out of range on either axis and on both
    send_px(OP_BLEND, 12'd256,  12'd0,    32'hFFFF_FFFF);
    send_px(OP_READ,  12'd0,    12'd256,  32'h0000_0000);
    send_px(OP_READ,  12'd4095, 12'd4095, 32'hFFFF_FFFF);
    send_px(OP_BLEND, 12'd4095, 12'd0,    32'hFFFF_FFFF);
    send_px(OP_BLEND, 12'd255,  12'd255,  32'hFF00_0000);
    send_px(OP_READ,  12'd255,  12'd255,  32'h0000_0000);
  endtask

  task automatic test_reset_frame();
    run_random(250);
  endtask

  task automatic test_unit_frame();
    set_frame_size(1, 1);
    run_random(80);
  endtask

  // zero width or zero height rejects every item
  task automatic test_empty_frame();
    set_frame_size(0, 256);
    run_random(30);
    set_frame_size(256, 0);
    run_random(30);
  endtask

  // sizes above the store saturate to 256 x 256
  task automatic test_oversized_frame();
    set_frame_size(511, 300);
    run_random(200);
  endtask

  // odd stride remaps the store addresses
  task automatic test_odd_frame();
    set_frame_size(17, 9);
    run_random(200);
  endtask

  task automatic test_single_row();
    set_frame_size(256, 1);
    run_random(100);
  endtask

  // closing phase at full rate on both sides
  task automatic test_full_rate();
    set_frame_size(40, 200);
    calm = 1'b1;
    run_random(150);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_px_q.size() == 0) begin
        $display("%0t: unexpected result item in_range=%0b pixel=%08h",
                 $time, m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        exp_px = expected_px_q.pop_front();
        if (m_axis_tuser !== exp_px.in_range) begin
          $display("%0t: in_range mismatch expected %0b actual %0b",
                   $time, exp_px.in_range, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== exp_px.pixel) begin
          $display("%0t: pixel mismatch expected %08h actual %08h",
                   $time, exp_px.pixel, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("framebuffer_alpha_blend_write verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_FRAME_WIDTH;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    fail_count    = 0;
    quiet_cycles  = 0;
    calm          = 1'b0;
    shadow_width  = 9'd256;
    shadow_height = 9'd256;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_reset_frame();
    test_unit_frame();
    test_empty_frame();
    test_oversized_frame();
    test_odd_frame();
    test_single_row();
    test_full_rate();
    drain();

    if (fail_count == 0 && expected_px_q.size() == 0) begin
      $display("framebuffer_alpha_blend_write verification clean");
    end else begin
      $display("framebuffer_alpha_blend_write verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/fab_pkg.sv
rtl/core/fab_mem.sv
rtl/core/fab_blend.sv
rtl/core/framebuffer_alpha_blend_write.sv
bench/testbench.sv
